// ===== rtl/convolutional_rate_matcher_top_macros.svh =====
// Assertion macros for the convolutional rate matcher checker
`ifndef CONVOLUTIONAL_RATE_MATCHER_TOP_MACROS_SVH
`define CONVOLUTIONAL_RATE_MATCHER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CRM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crm: implication check failed");

// next-cycle implication, disabled while reset is low
`define CRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crm: next-cycle check failed");

// next-cycle implication that also holds through reset
`define CRM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("crm: reset check failed");

`endif

// ===== rtl/crm_pkg.sv =====
// Types, constants and the column permutation of the convolutional rate matcher
`default_nettype none
package crm_pkg;

    localparam int NUM_COLS     = 32;
    localparam int COL_W        = $clog2(NUM_COLS);
    localparam int NUM_STREAMS  = 3;
    localparam int STREAM_W     = 2;
    localparam int DEF_MAX_ROWS = 8;
    localparam int OUT_LEN_W    = 16;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_RESET = 16'd1600;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [COL_W-1:0] COL_PERM [0:NUM_COLS-1] = '{
        5'd1, 5'd17, 5'd9,  5'd25, 5'd5, 5'd21, 5'd13, 5'd29,
        5'd3, 5'd19, 5'd11, 5'd27, 5'd7, 5'd23, 5'd15, 5'd31,
        5'd0, 5'd16, 5'd8,  5'd24, 5'd4, 5'd20, 5'd12, 5'd28,
        5'd2, 5'd18, 5'd10, 5'd26, 5'd6, 5'd22, 5'd14, 5'd30
    };

    typedef struct packed {
        logic op;
        logic first;
        logic bit_stream0;
        logic bit_stream1;
        logic bit_stream2;
    } t_cmd;

    typedef struct packed {
        logic out_bit;
        logic is_last;
        logic no_data;
    } t_res;

    // classified word held in the queue
    typedef struct packed {
        logic                      is_emit;
        logic                      first;
        logic [NUM_STREAMS-1:0]    bits;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qhead;

    function automatic logic [COL_W-1:0] col_perm(input logic [COL_W-1:0] col);
        return COL_PERM[col];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/crm_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none
module crm_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/crm_front.sv =====
// Front end: accepts command words, classifies them and queues them
`default_nettype none
module crm_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire crm_pkg::t_cmd i_cmd,
    output crm_pkg::t_qhead    o_head,
    input  wire logic          i_pop
);
    import crm_pkg::*;

    localparam int QDEPTH = 2;

    t_job       r_q [0:QDEPTH-1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_job       job_in;

    assign busy = (r_cnt == 2'(QDEPTH));
    assign push = start && !busy;
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_comb begin
        job_in.is_emit = (i_cmd.op == OP_EMIT);
        job_in.first   = i_cmd.first;
        job_in.bits    = {i_cmd.bit_stream2, i_cmd.bit_stream1, i_cmd.bit_stream0};
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/crm_back.sv =====
// Back end: stores bit triples and runs the interleaved circular read
`default_nettype none
module crm_back #(
    parameter int MAX_ROWS = crm_pkg::DEF_MAX_ROWS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire crm_pkg::t_qhead                  i_head,
    output logic                                  o_pop,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [crm_pkg::OUT_LEN_W-1:0]    i_cfg_data,
    output logic                                  o_res_strobe,
    output crm_pkg::t_res                         o_res
);
    import crm_pkg::*;

    localparam int DEPTH = NUM_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int PW    = RW + COL_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [STREAM_W-1:0]  r_stream, n_stream;
    logic [COL_W-1:0]     r_col, n_col;
    logic [RW-1:0]        r_row, n_row;
    logic [OUT_LEN_W-1:0] r_emitted, n_emitted;
    logic [OUT_LEN_W-1:0] r_out_len;
    logic [STREAM_W-1:0]  r_sel, n_sel;
    logic                 r_strobe, n_strobe;
    t_res                 r_res, n_res;

    logic [CW:0]          cnt_round;
    logic [RCW-1:0]       rows;
    logic [COL_W-1:0]     dummies;
    logic [PW-1:0]        pos;
    logic                 hit;
    logic [AW-1:0]        rd_addr;
    logic [RCW-1:0]       row_inc;
    logic [COL_W-1:0]     adv_col;
    logic [RW-1:0]        adv_row;
    logic [STREAM_W-1:0]  adv_stream;
    logic [CW-1:0]        ld_base;
    logic [OUT_LEN_W-1:0] emit_inc;
    logic                 ram_we, ram_re;
    logic [NUM_STREAMS-1:0] ram_rdata;

    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // row count and leading dummy count of the current block
    assign cnt_round = {1'b0, r_count} + (CW + 1)'(NUM_COLS - 1);
    assign rows      = RCW'(cnt_round >> COL_W);
    assign dummies   = COL_W'(0) - r_count[COL_W-1:0];

    // one search step: current position and the position after it
    assign pos     = {r_row, col_perm(r_col)};
    assign hit     = (pos >= PW'(dummies));
    assign rd_addr = AW'(pos - PW'(dummies));
    assign row_inc = RCW'(r_row) + RCW'(1);

    always_comb begin
        adv_row    = RW'(row_inc);
        adv_col    = r_col;
        adv_stream = r_stream;
        if (row_inc >= rows) begin
            adv_row = '0;
            adv_col = r_col + COL_W'(1);
            if (r_col == COL_W'(NUM_COLS - 1)) begin
                adv_stream = (r_stream == STREAM_W'(NUM_STREAMS - 1)) ?
                             '0 : r_stream + STREAM_W'(1);
            end
        end
    end

    assign ld_base  = i_head.job.first ? '0 : r_count;
    assign emit_inc = r_emitted + OUT_LEN_W'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_stream  = r_stream;
        n_col     = r_col;
        n_row     = r_row;
        n_emitted = r_emitted;
        n_sel     = r_sel;
        n_strobe  = 1'b0;
        n_res     = r_res;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (!i_head.job.is_emit) begin
                        if (i_head.job.first) begin
                            n_emitted = '0;
                            n_stream  = '0;
                            n_col     = '0;
                            n_row     = '0;
                        end
                        // drop the triple once the store is full
                        n_count = ld_base;
                        if (ld_base < CW'(DEPTH)) begin
                            ram_we  = 1'b1;
                            n_count = ld_base + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_strobe      = 1'b1;
                        n_res.out_bit = 1'b0;
                        n_res.is_last = 1'b0;
                        n_res.no_data = 1'b1;
                    end else begin
                        n_stream = adv_stream;
                        n_col    = adv_col;
                        n_row    = adv_row;
                        n_sel    = r_stream;
                        ram_re   = hit;
                        n_state  = hit ? ST_READ : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // skip dummy positions one per cycle
                n_stream = adv_stream;
                n_col    = adv_col;
                n_row    = adv_row;
                n_sel    = r_stream;
                ram_re   = hit;
                n_state  = hit ? ST_READ : ST_SEARCH;
            end
            ST_READ: begin
                n_strobe      = 1'b1;
                n_res.out_bit = ram_rdata[r_sel];
                n_res.no_data = 1'b0;
                n_res.is_last = (emit_inc == r_out_len);
                n_emitted     = emit_inc;
                if (emit_inc == r_out_len) begin
                    n_emitted = '0;
                    n_stream  = '0;
                    n_col     = '0;
                    n_row     = '0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    crm_ram #(
        .WIDTH (NUM_STREAMS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ld_base[AW-1:0]),
        .i_wdata (i_head.job.bits),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_stream  <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_emitted <= '0;
            r_strobe  <= 1'b0;
            r_out_len <= OUT_LEN_RESET;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_stream  <= n_stream;
            r_col     <= n_col;
            r_row     <= n_row;
            r_emitted <= n_emitted;
            r_strobe  <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_out_len <= i_cfg_data;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/convolutional_rate_matcher_top.sv =====
// Top level of the convolutional rate matcher
//
//  channel   signals                              handshake
//  command   i_cmd (t_cmd)                        start & !busy
//  result    o_res (t_res)                        o_res_strobe, one cycle
//  config    i_cfg_data (output_length)           i_cfg_valid & o_cfg_ready
//
// A load word is written from the idle state; an emit word takes a position
// step plus registered store read, and a search step for each dummy position
// skipped, at most NUM_COLS-1 in a row. An emit with nothing loaded gets no_data.
// The two-word queue keeps accepting while the back end works; busy means full.
// Reset clears the queue, counters and read position; the bit store keeps
// its contents. Results are shown for one cycle and cannot be held off.
`default_nettype none
module convolutional_rate_matcher_top #(
    parameter int MAX_ROWS = crm_pkg::DEF_MAX_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire crm_pkg::t_cmd                 i_cmd,
    output logic                               o_res_strobe,
    output crm_pkg::t_res                      o_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [crm_pkg::OUT_LEN_W-1:0] i_cfg_data
);
    import crm_pkg::*;

    t_qhead head;
    logic   pop;

    crm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_head  (head),
        .i_pop   (pop)
    );

    crm_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );
endmodule
`default_nettype wire

// ===== rtl/crm_checker.sv =====
// Port-level checker for the convolutional rate matcher, bound to the top
`default_nettype none
`include "convolutional_rate_matcher_top_macros.svh"
module crm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          busy,
    input wire logic          o_res_strobe,
    input wire crm_pkg::t_res o_res,
    input wire logic          o_cfg_ready
);
    import crm_pkg::*;

    // an empty-store result carries no bit and never ends a sequence
    `CRM_ASSERT_IMPLY(a_nodata_clean, i_clk, i_rst_n, o_res_strobe && o_res.no_data, !o_res.out_bit && !o_res.is_last)
    // a real bit needs a store read, so it is never followed at once by another result
    `CRM_ASSERT_NEXT(a_bit_spacing, i_clk, i_rst_n, o_res_strobe && !o_res.no_data, !o_res_strobe)
    // reset empties the queue and silences the result port
    `CRM_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !busy && !o_res_strobe)
    // the register port never stalls
    `CRM_ASSERT_IMPLY(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready)
endmodule

bind convolutional_rate_matcher_top crm_checker u_crm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res),
    .o_cfg_ready  (o_cfg_ready)
);
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the convolutional rate matcher: directed table, then random blocks
`timescale 1ns / 100ps

module testbench;

    import crm_pkg::*;

    localparam int  COLS       = 32;
    localparam int  DEPTH      = 32 * 8;
    localparam int  STREAMS    = 3;
    localparam int  TAIL       = 4;
    localparam int  LIMIT      = 500000;
    localparam int  DIR_ROWS   = 23;
    localparam logic ROW_WORD  = 1'b0;
    localparam logic ROW_LEN   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] len;
        t_cmd        cmd;
        logic        typed;
        t_res        want;
    } t_dir_row;

    // typed results: empty emit after reset, and a one-triple block at length 1
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
        '{ROW_LEN,  16'd1, '{OP_LOAD, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_LOAD, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{ROW_LEN,  16'd3, '{OP_LOAD, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_LOAD, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_LEN,  16'd0, '{OP_LOAD, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_LOAD, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_LOAD, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_LEN,  16'hFFFF, '{OP_LOAD, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_LOAD, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_LOAD, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, 16'd0, '{OP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_cmd              i_cmd;
    logic              o_res_strobe;
    t_res              o_res;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [OUT_LEN_W-1:0] i_cfg_data;

    // matcher state as the predictor sees it
    logic [2:0]        triple_mem [DEPTH];
    int                fill;
    int                rd_stream;
    int                rd_col;
    int                rd_row;
    logic [15:0]       bit_count;
    logic [15:0]       seq_length;

    t_res              expected_bits [$];
    t_res              want_now;
    int                err_count = 0;
    int                cycles = 0;
    int                gap_pct = 0;

    convolutional_rate_matcher_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, expected_bits.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void clear_read();
        rd_stream = 0;
        rd_col    = 0;
        rd_row    = 0;
    endfunction

    // step rows, then columns, then streams, wrapping each
    function automatic void step_read(input int rows);
        rd_row++;
        if (rd_row >= rows) begin
            rd_row = 0;
            rd_col++;
            if (rd_col >= COLS) begin
                rd_col = 0;
                rd_stream++;
                if (rd_stream >= STREAMS) begin
                    rd_stream = 0;
                end
            end
        end
    endfunction

    task automatic predict_word(input t_cmd c, output bit gives, output t_res r);
        int         rows;
        int         holes;
        int         pos;
        int         guard;
        bit         found;
        logic [4:0] cc;
        r     = '0;
        gives = 1'b0;
        if (c.op == OP_LOAD) begin
            if (c.first) begin
                fill      = 0;
                bit_count = '0;
                clear_read();
            end
            // drop loads past a full store
            if (fill < DEPTH) begin
                triple_mem[fill] = {c.bit_stream2, c.bit_stream1, c.bit_stream0};
                fill++;
            end
        end else begin
            gives = 1'b1;
            if (fill == 0) begin
                r.no_data = 1'b1;
            end else begin
                rows  = (fill + COLS - 1) / COLS;
                holes = rows * COLS - fill;
                if (rd_stream >= STREAMS) begin
                    clear_read();
                end
                if (rd_col >= COLS) begin
                    rd_col = 0;
                end
                if (rd_row >= rows) begin
                    rd_row = rows - 1;
                    step_read(rows);
                end
                found = 1'b0;
                for (guard = 0; guard <= STREAMS * DEPTH && !found; guard++) begin
                    cc = rd_col[4:0];
                    // column permutation: bit reversal of the column with its top bit flipped
                    pos   = rd_row * COLS + int'({cc[0], cc[1], cc[2], cc[3], ~cc[4]});
                    found = (pos >= holes) && (pos - holes < fill);
                    if (found) begin
                        r.out_bit = triple_mem[pos - holes][rd_stream];
                    end
                    step_read(rows);
                end
                bit_count = bit_count + 16'd1;
                if (bit_count == seq_length) begin
                    r.is_last = 1'b1;
                    bit_count = '0;
                    clear_read();
                end
            end
        end
    endtask

    task automatic report(input string field, input logic exp_v, input logic act_v);
        err_count++;
        $display("%0t: %s mismatch, expected %b actual %b", $time, field, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            if (expected_bits.size() == 0) begin
                report("unexpected result, no_data", 1'b0, o_res.no_data);
            end else begin
                want_now = expected_bits.pop_front();
                if (o_res.out_bit !== want_now.out_bit) begin
                    report("out_bit", want_now.out_bit, o_res.out_bit);
                end
                if (o_res.is_last !== want_now.is_last) begin
                    report("is_last", want_now.is_last, o_res.is_last);
                end
                if (o_res.no_data !== want_now.no_data) begin
                    report("no_data", want_now.no_data, o_res.no_data);
                end
            end
        end
    end

    task automatic send_word(input t_cmd c, input bit typed, input t_res want);
        bit   gives;
        t_res calc;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predict_word(c, gives, calc);
        if (gives) begin
            expected_bits.insert(expected_bits.size(), typed ? want : calc);
        end
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_load(input logic first);
        t_cmd c;
        c       = t_cmd'($urandom);
        c.op    = OP_LOAD;
        c.first = first;
        send_word(c, 1'b0, '0);
    endtask

    task automatic send_emit();
        t_cmd c;
        c    = t_cmd'($urandom);
        c.op = OP_EMIT;
        send_word(c, 1'b0, '0);
    endtask

    // hold off new words until every result is back and the back end is quiet
    task automatic settle();
        start <= 1'b0;
        while (expected_bits.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [15:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seq_length = v;
    endtask

    // blocks opened with first, filled, then read with some growth and restarts mixed in
    task automatic run_blocks(input int budget);
        int done;
        int d;
        int n;
        int k;
        int pick;
        done = 0;
        while (done < budget) begin
            d = ($urandom_range(19) == 0) ? $urandom_range(41, 255) : $urandom_range(1, 40);
            for (k = 0; k < d; k++) begin
                send_load(k == 0);
            end
            n = $urandom_range(1, 60);
            for (k = 0; k < n; k++) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    send_load(1'b0);
                end else if (pick < 8) begin
                    send_load(1'b1);
                end else begin
                    send_emit();
                end
            end
            if (gap_pct != 0 && $urandom_range(15) == 0) begin
                settle();
            end
            done += d + n;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        for (int j = 0; j < DEPTH; j++) begin
            triple_mem[j] = '0;
        end
        fill       = 0;
        bit_count  = '0;
        seq_length = OUT_LEN_RESET;
        clear_read();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 25;
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_LEN) begin
                write_length(DIRECTED[i].len);
            end else begin
                send_word(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        write_length(16'd40);
        gap_pct = 30;
        run_blocks(40);

        write_length(16'd1);
        gap_pct = 50;
        run_blocks(20);

        // fill the store past capacity, then read deep into the big block
        write_length(16'hFFFF);
        gap_pct = 20;
        for (int k = 0; k < DEPTH + 3; k++) begin
            send_load(k == 0);
        end
        repeat (30) send_emit();
        run_blocks(10);

        write_length(16'd0);
        gap_pct = 0;
        run_blocks(20);

        write_length(16'd13);
        gap_pct = 40;
        run_blocks(20);

        write_length(16'd97);
        gap_pct = 0;
        run_blocks(40);

        settle();
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
